// ----- design/assert_macros.svh -----
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ffra_pkg.sv -----
// Types and constants of the first-fit range allocator.
package ffra_pkg;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_BAD_FREE = 2'd3;

	localparam logic [31:0] HEAP_RESET = 32'd1048576;

	// Chain commands.
	localparam logic [1:0] CH_HOLD = 2'd0;
	localparam logic [1:0] CH_ROT  = 2'd1;
	localparam logic [1:0] CH_INS  = 2'd2;
	localparam logic [1:0] CH_DEL  = 2'd3;

	// Wide enough for any table position up to 1024 entries.
	localparam int POS_W = 10;

	typedef struct packed {
		logic [1:0]       op;
		logic [POS_W-1:0] pos;
	} chain_cmd_t;

	typedef struct packed {
		logic        action;
		logic [31:0] req_size;
		logic [4:0]  align_log2;
		logic [31:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] chunk_offset;
		logic [31:0] chunk_length;
		logic [31:0] free_bytes;
		logic [6:0]  live_count;
	} rsp_t;

endpackage

// ----- design/ffra_if.sv -----
// Handshake channel interfaces of the first-fit range allocator.
interface ffra_req_if;
	logic                 valid;
	logic                 ready;
	ffra_pkg::req_t       data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ffra_rsp_if;
	logic                 valid;
	logic                 ready;
	ffra_pkg::rsp_t       data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ffra_cfg_if;
	logic                 valid;
	logic                 ready;
	logic [31:0]          data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/ffra_cell.sv -----
// One table cell: holds one range and moves it along the chain on command.
module ffra_cell #(
	parameter int ADDR_BITS = 32,
	parameter int IDX = 0
) (
	input  logic                   clk,
	input  ffra_pkg::chain_cmd_t   cmd,
	input  logic [ADDR_BITS-1:0]   new_start,
	input  logic [ADDR_BITS-1:0]   new_len,
	input  logic [ADDR_BITS-1:0]   left_start,
	input  logic [ADDR_BITS-1:0]   left_len,
	input  logic [ADDR_BITS-1:0]   right_start,
	input  logic [ADDR_BITS-1:0]   right_len,
	output logic [ADDR_BITS-1:0]   start,
	output logic [ADDR_BITS-1:0]   len
);
	import ffra_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			CH_HOLD: begin
				start <= start;
				len   <= len;
			end
			CH_ROT: begin
				start <= right_start;
				len   <= right_len;
			end
			CH_INS: begin
				if (MY_POS > cmd.pos) begin
					start <= left_start;
					len   <= left_len;
				end else if (MY_POS == cmd.pos) begin
					start <= new_start;
					len   <= new_len;
				end
			end
			CH_DEL: begin
				if (MY_POS >= cmd.pos) begin
					start <= right_start;
					len   <= right_len;
				end
			end
		endcase
	end

endmodule

// ----- design/ffra_chain.sv -----
// Ring of table cells; cell 0 is the head seen by the controller.
module ffra_chain #(
	parameter int MAX_RANGES = 64,
	parameter int ADDR_BITS = 32
) (
	input  logic                   clk,
	input  ffra_pkg::chain_cmd_t   cmd,
	input  logic [ADDR_BITS-1:0]   new_start,
	input  logic [ADDR_BITS-1:0]   new_len,
	output logic [ADDR_BITS-1:0]   head_start,
	output logic [ADDR_BITS-1:0]   head_len
);
	logic [ADDR_BITS-1:0] st [MAX_RANGES];
	logic [ADDR_BITS-1:0] ln [MAX_RANGES];

	for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
		ffra_cell #(
			.ADDR_BITS (ADDR_BITS),
			.IDX       (i)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.new_start   (new_start),
			.new_len     (new_len),
			.left_start  (st[(i + MAX_RANGES - 1) % MAX_RANGES]),
			.left_len    (ln[(i + MAX_RANGES - 1) % MAX_RANGES]),
			.right_start (st[(i + 1) % MAX_RANGES]),
			.right_len   (ln[(i + 1) % MAX_RANGES]),
			.start       (st[i]),
			.len         (ln[i])
		);
	end

	assign head_start = st[0];
	assign head_len   = ln[0];

endmodule

// ----- design/first_fit_range_allocator.sv -----
// Top level of the first-fit range allocator: controller, scan pipeline and cell chain.
// The block keeps up to MAX_RANGES allocated ranges, sorted by start offset, in a ring
// of cells. Each allocate or free transaction rotates the whole ring once, one entry
// per cycle past the head cell, while the controller looks for the range to free, the
// first aligned gap between neighbors and the room after the last range. The ring
// comes back to its original order, and a single chain command then opens or closes a
// slot by shifting every cell above the chosen position toward its neighbor, once the
// result can be taken. A transaction thus runs through the ring rotation and then
// drains a two-stage alignment pipeline before it finishes; an allocate on an empty
// or a full table skips the rotation. A finished result sits in an output register,
// so the next request is taken while the result still waits. A write on the cfg
// channel sets the heap size, clears the table and resets the free byte count; write
// it only when no transaction is in flight.
`include "assert_macros.svh"

module first_fit_range_allocator #(
	parameter int MAX_RANGES = 64,
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ffra_cfg_if.sink    cfg,
	ffra_req_if.sink    req,
	ffra_rsp_if.source  rsp
);
	import ffra_pkg::*;

	localparam int IW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int AW = ADDR_BITS;
	// Room for the aligned end of any range plus the largest alignment.
	localparam int EW = ((AW > 31) ? AW : 31) + 2;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	// Control state.
	logic [1:0]    state_q;
	logic [IW-1:0] step_q;
	logic          drain_q;
	logic [AW-1:0] heap_q;
	logic [AW-1:0] bytes_q;
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	logic          first_hit_q;
	logic          last_hit_q;

	// Request held for the whole transaction.
	logic          op_q;
	logic [AW-1:0] size_q;
	logic [4:0]    align_q;
	logic [AW-1:0] off_q;

	// Decisions found during the scan.
	logic [IW-1:0] first_pos_q;
	logic [AW-1:0] first_off_q;
	logic [AW-1:0] first_len_q;
	logic [AW-1:0] last_off_q;

	// Alignment pipeline: end of a range, then its aligned end.
	logic          v_s1;
	logic [IW-1:0] idx_s1;
	logic [AW-1:0] start_s1;
	logic [AW:0]   sum_s1;
	logic          v_s2;
	logic [IW-1:0] idx_s2;
	logic [AW-1:0] start_s2;
	logic [AW-1:0] ae_s2;
	logic          aeok_s2;
	logic [AW-1:0] ae_s3;
	logic          aeok_s3;

	rsp_t          rsp_q;

	logic          cfg_fire;
	logic          req_fire;
	logic [AW-1:0] head_start;
	logic [AW-1:0] head_len;
	logic          step_live;
	logic [EW-1:0] al_m1;
	logic [EW-1:0] s_ext;
	logic [EW-1:0] a_ext;
	logic          aeok_n;
	logic [AW-1:0] ae_n;
	logic          fr_ok;
	logic          gap_ok;
	logic          last_ok;
	logic          fin_go;
	logic [1:0]    status_n;
	logic [AW-1:0] off_n;
	logic [AW-1:0] len_n;
	logic          ins_n;
	logic          del_n;
	logic [IW-1:0] pos_n;
	logic [AW-1:0] bytes_next;
	logic [CW-1:0] count_next;
	chain_cmd_t    cmd;

	assign cfg_fire = cfg.valid & cfg.ready;
	assign req_fire = req.valid & req.ready;

	// Configuration takes precedence over a request in the same idle cycle.
	assign cfg.ready = (state_q == S_IDLE);
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// Head entry of the ring is table entry step_q during the scan.
	assign step_live = (CW'(step_q) < count_q);

	// Aligned end of the entry in stage 1; unusable if it leaves the address space.
	always_comb begin
		al_m1  = (EW'(1) << align_q) - EW'(1);
		s_ext  = EW'(sum_s1);
		a_ext  = s_ext + al_m1;
		aeok_n = (s_ext[EW-1:AW] == '0) && (a_ext[EW-1:AW] == '0);
		ae_n   = AW'(a_ext & ~al_m1);
	end

	// Free: first entry whose start is not below the offset.
	assign fr_ok = (state_q == S_SCAN) && (op_q == ACT_FREE) && step_live &&
		(head_start >= off_q);

	// Gap between the previous entry (stage 3) and the entry in stage 2.
	assign gap_ok = v_s2 && (idx_s2 != '0) && aeok_s3 && (ae_s3 <= start_s2) &&
		((start_s2 - ae_s3) >= size_q);

	// Room after the last entry, up to the heap end.
	assign last_ok = v_s2 && ((CW'(idx_s2) + CW'(1)) == count_q) && aeok_s2 &&
		(ae_s2 <= heap_q) && ((heap_q - ae_s2) >= size_q);

	assign fin_go = (state_q == S_FINISH) && (!rsp_valid_q || rsp.ready);

	// Outcome of the transaction, in the order the rules apply.
	always_comb begin
		status_n = ST_NO_SPACE;
		off_n    = '0;
		len_n    = '0;
		ins_n    = 1'b0;
		del_n    = 1'b0;
		pos_n    = '0;
		priority if (op_q == ACT_FREE) begin
			if (first_hit_q) begin
				status_n = ST_OK;
				off_n    = first_off_q;
				len_n    = first_len_q;
				del_n    = 1'b1;
				pos_n    = first_pos_q;
			end else begin
				status_n = ST_BAD_FREE;
			end
		end else if (count_q == CW'(MAX_RANGES)) begin
			status_n = ST_FULL;
		end else if (count_q == '0) begin
			if (size_q <= heap_q) begin
				status_n = ST_OK;
				len_n    = size_q;
				ins_n    = 1'b1;
			end
		end else if (last_hit_q) begin
			status_n = ST_OK;
			off_n    = last_off_q;
			len_n    = size_q;
			ins_n    = 1'b1;
			pos_n    = IW'(count_q);
		end else if (first_hit_q) begin
			status_n = ST_OK;
			off_n    = first_off_q;
			len_n    = size_q;
			ins_n    = 1'b1;
			pos_n    = first_pos_q;
		end else begin
			status_n = ST_NO_SPACE;
		end
	end

	always_comb begin
		bytes_next = bytes_q;
		count_next = count_q;
		if (ins_n) begin
			bytes_next = bytes_q - len_n;
			count_next = count_q + CW'(1);
		end else if (del_n) begin
			bytes_next = bytes_q + len_n;
			count_next = count_q - CW'(1);
		end
	end

	// Rotate during the scan; open or close a slot when the result is taken.
	always_comb begin
		cmd.op  = CH_HOLD;
		cmd.pos = POS_W'(pos_n);
		if (state_q == S_SCAN) begin
			cmd.op = CH_ROT;
		end else if (fin_go && ins_n) begin
			cmd.op = CH_INS;
		end else if (fin_go && del_n) begin
			cmd.op = CH_DEL;
		end
	end

	ffra_chain #(
		.MAX_RANGES (MAX_RANGES),
		.ADDR_BITS  (ADDR_BITS)
	) u_chain (
		.clk        (clk),
		.cmd        (cmd),
		.new_start  (off_n),
		.new_len    (len_n),
		.head_start (head_start),
		.head_len   (head_len)
	);

	// Sequencer and table bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			drain_q     <= 1'b0;
			heap_q      <= AW'(HEAP_RESET);
			bytes_q     <= AW'(HEAP_RESET);
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			first_hit_q <= 1'b0;
			last_hit_q  <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_fire) begin
						heap_q  <= AW'(cfg.data);
						bytes_q <= AW'(cfg.data);
						count_q <= '0;
					end else if (req_fire) begin
						first_hit_q <= 1'b0;
						last_hit_q  <= 1'b0;
						step_q      <= '0;
						// An allocate on an empty or full table needs no scan.
						if (req.data.action == ACT_ALLOC &&
							(count_q == '0 || count_q == CW'(MAX_RANGES))) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					step_q <= step_q + IW'(1);
					if (step_q == IW'(MAX_RANGES - 1)) begin
						drain_q <= 1'b0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						bytes_q     <= bytes_next;
						count_q     <= count_next;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
			endcase
			// Keep the first hit only; the last-range check always wins later.
			if (!first_hit_q && (fr_ok || gap_ok)) begin
				first_hit_q <= 1'b1;
			end
			if (op_q == ACT_ALLOC && last_ok) begin
				last_hit_q <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q    <= req.data.action;
			size_q  <= AW'(req.data.req_size);
			align_q <= req.data.align_log2;
			off_q   <= AW'(req.data.free_offset);
		end
		if (!first_hit_q && (fr_ok || gap_ok)) begin
			first_pos_q <= fr_ok ? step_q : idx_s2;
			first_off_q <= fr_ok ? head_start : ae_s3;
			first_len_q <= fr_ok ? head_len : size_q;
		end
		if (last_ok) begin
			last_off_q <= ae_s2;
		end
		v_s1     <= (state_q == S_SCAN) && (op_q == ACT_ALLOC) && step_live;
		idx_s1   <= step_q;
		start_s1 <= head_start;
		sum_s1   <= (AW + 1)'(head_start) + (AW + 1)'(head_len);
		v_s2     <= v_s1;
		idx_s2   <= idx_s1;
		start_s2 <= start_s1;
		ae_s2    <= ae_n;
		aeok_s2  <= aeok_n;
		ae_s3    <= ae_s2;
		aeok_s3  <= aeok_s2;
		if (fin_go) begin
			rsp_q.status       <= status_n;
			rsp_q.chunk_offset <= 32'(off_n);
			rsp_q.chunk_length <= 32'(len_n);
			rsp_q.free_bytes   <= 32'(bytes_next);
			rsp_q.live_count   <= 7'(count_next);
		end
	end

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CW'(MAX_RANGES), "live count above table size")
	`ASSERT_NEXT(a_finish_idle, clk, arst_n, fin_go, (state_q == S_IDLE) && rsp_valid_q, "finish did not post a result")
	`ASSERT_NEXT(a_scan_len, clk, arst_n, (state_q == S_SCAN) && (step_q == IW'(MAX_RANGES - 1)), state_q == S_DRAIN, "scan did not end after one rotation")
	`ASSERT_NEXT(a_free_count, clk, arst_n, fin_go && del_n, count_q == $past(count_q) - CW'(1), "free did not drop the live count")

endmodule
